[rtl/core/i2d_pkg.sv]
// ----------------------------------------------------------------------------
// i2d_pkg
// Shared types and constants for the integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package i2d_pkg;

  // magnitude bits of a non-negative 64-bit two's complement value
  localparam int MAG_W = 63;
  // decimal digits needed for the largest 63-bit magnitude
  localparam int NDIG = 19;
  localparam int NDIG_W = 5;
  localparam int BCD_W = NDIG * 4;
  // shift counter covers MAG_W steps
  localparam int SHIFT_W = 6;

  localparam logic [6:0] CHAR_ZERO = 7'h30;

  typedef logic [BCD_W-1:0] bcd_t;

  // converter to emitter transfer
  typedef struct packed {
    bcd_t bcd;
    logic neg;
  } bcd_xfer_t;

  // add 3 to every BCD digit of 5 or more before the next left shift
  function automatic bcd_t dabble(input bcd_t b);
    bcd_t r;
    logic [3:0] d;
    r = b;
    for (int i = 0; i < NDIG; i++) begin
      d = b[i*4 +: 4];
      if (d >= 4'd5) begin
        r[i*4 +: 4] = d + 4'd3;
      end
    end
    return r;
  endfunction

endpackage

[rtl/core/i2d_if.sv]
// ----------------------------------------------------------------------------
// i2d_if
// Valid/ready channels for the integer input and the character results.
// ----------------------------------------------------------------------------
interface i2d_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [4:0]  min_digits;

  modport source (output valid, output value, output min_digits, input ready);
  modport sink (input valid, input value, input min_digits, output ready);
endinterface

interface i2d_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] digit_char;
  logic       is_last;
  logic       negative_error;
  logic [4:0] length;

  modport source (output valid, output digit_char, output is_last,
                  output negative_error, output length, input ready);
  modport sink (input valid, input digit_char, input is_last,
                input negative_error, input length, output ready);
endinterface

[rtl/core/i2d_conv.sv]
// ----------------------------------------------------------------------------
// i2d_conv
// Bit-serial binary to BCD converter: one magnitude bit enters per cycle.
// ----------------------------------------------------------------------------
module i2d_conv #(
  parameter int PAD_W = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  start_ready,
  input  logic [63:0]           value,
  input  logic [PAD_W-1:0]      pad_in,
  output logic                  done_valid,
  input  logic                  done_ready,
  output i2d_pkg::bcd_xfer_t    done_data,
  output logic [PAD_W-1:0]      pad_out
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SHIFT = 2'd1;
  localparam logic [1:0] ST_DONE  = 2'd2;

  logic [1:0]                    state;
  logic [i2d_pkg::MAG_W-1:0]     bin;
  i2d_pkg::bcd_t                 bcd;
  i2d_pkg::bcd_t                 bcd_adj;
  logic [i2d_pkg::SHIFT_W-1:0]   cnt;
  logic                          neg;
  logic [PAD_W-1:0]              pad;

  assign start_ready = (state == ST_IDLE);
  assign done_valid  = (state == ST_DONE);
  assign done_data   = '{bcd: bcd, neg: neg};
  assign pad_out     = pad;
  assign bcd_adj     = i2d_pkg::dabble(bcd);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            bin   <= value[i2d_pkg::MAG_W-1:0];
            neg   <= value[63];
            pad   <= pad_in;
            bcd   <= '0;
            cnt   <= i2d_pkg::SHIFT_W'(i2d_pkg::MAG_W - 1);
            // negative input skips conversion
            state <= value[63] ? ST_DONE : ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          bcd <= {bcd_adj[i2d_pkg::BCD_W-2:0], bin[i2d_pkg::MAG_W-1]};
          bin <= {bin[i2d_pkg::MAG_W-2:0], 1'b0};
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (done_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/core/i2d_emit.sv]
// ----------------------------------------------------------------------------
// i2d_emit
// Strips leading zero digits, then shifts out one ASCII character per cycle
// into the output register while it is free, with padding zeros in front.
// ----------------------------------------------------------------------------
module i2d_emit #(
  parameter int PAD_W = 5,
  parameter int LEN_W = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               load_valid,
  output logic               load_ready,
  input  i2d_pkg::bcd_xfer_t load_data,
  input  logic [PAD_W-1:0]   pad_in,
  i2d_out_if.source          out_ch
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_TRIM = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]                  state;
  i2d_pkg::bcd_t               bcd;
  logic                        neg;
  logic [PAD_W-1:0]            pad;
  logic [i2d_pkg::NDIG_W-1:0]  ndig;
  logic [LEN_W-1:0]            zeros;
  logic [LEN_W-1:0]            len;
  logic [LEN_W-1:0]            len_next;
  logic [LEN_W-1:0]            ndig_ext;
  logic [LEN_W-1:0]            pad_ext;
  logic [3:0]                  top;
  logic                        slot_free;
  logic                        emit_fire;

  logic       out_valid;
  logic [6:0] digit_char;
  logic       is_last;
  logic       negative_error;
  logic [4:0] length;

  assign top       = bcd[i2d_pkg::BCD_W-1 -: 4];
  assign ndig_ext  = LEN_W'(ndig);
  assign pad_ext   = LEN_W'(pad);
  assign len_next  = len + 1'b1;
  assign slot_free = !out_valid || out_ch.ready;
  assign emit_fire = (state == ST_EMIT) && slot_free;
  assign load_ready = (state == ST_IDLE);

  assign out_ch.valid          = out_valid;
  assign out_ch.digit_char     = digit_char;
  assign out_ch.is_last        = is_last;
  assign out_ch.negative_error = negative_error;
  assign out_ch.length         = length;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready && !emit_fire) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (load_valid) begin
            bcd   <= load_data.bcd;
            neg   <= load_data.neg;
            pad   <= pad_in;
            ndig  <= i2d_pkg::NDIG_W'(i2d_pkg::NDIG);
            len   <= '0;
            state <= load_data.neg ? ST_EMIT : ST_TRIM;
          end
        end
        ST_TRIM: begin
          // drop leading zero digits, keep at least one
          if (top == 4'd0 && ndig > i2d_pkg::NDIG_W'(1)) begin
            bcd  <= {bcd[i2d_pkg::BCD_W-5:0], 4'd0};
            ndig <= ndig - 1'b1;
          end else begin
            zeros <= (pad_ext > ndig_ext) ? (pad_ext - ndig_ext) : '0;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            if (neg) begin
              digit_char     <= 7'd0;
              is_last        <= 1'b1;
              negative_error <= 1'b1;
              length         <= 5'd0;
              state          <= ST_IDLE;
            end else if (zeros != '0) begin
              digit_char     <= i2d_pkg::CHAR_ZERO;
              is_last        <= 1'b0;
              negative_error <= 1'b0;
              length         <= len_next[4:0];
              len            <= len_next;
              zeros          <= zeros - 1'b1;
            end else begin
              digit_char     <= i2d_pkg::CHAR_ZERO + {3'b000, top};
              is_last        <= (ndig == i2d_pkg::NDIG_W'(1));
              negative_error <= 1'b0;
              length         <= len_next[4:0];
              len            <= len_next;
              bcd            <= {bcd[i2d_pkg::BCD_W-5:0], 4'd0};
              ndig           <= ndig - 1'b1;
              if (ndig == i2d_pkg::NDIG_W'(1)) begin
                state <= ST_IDLE;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/core/integer_to_decimal_ascii.sv]
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii
// Signed 64-bit integer to decimal ASCII characters, most significant first.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries value and min_digits; a transfer takes one integer.
//   out_ch carries one character per transfer with is_last, negative_error
//   and the running length. min_digits above MAX_DIGITS acts as MAX_DIGITS;
//   zero gives a single '0'; a negative value gives one error result.
// Flow:
//   The converter shifts the 63 magnitude bits into a BCD register, one bit
//   per cycle, then hands the result to the emitter once it is idle. The
//   emitter strips leading zero digits one per cycle, then sets the padding
//   count and sends one character per cycle while the receiver takes them.
//   A negative value skips the shift loop and the stripping and goes straight
//   to its single error result. The converter takes the next integer while
//   the emitter still sends.
// Reset and stalls:
//   rst (synchronous) empties both stages and the output register. in_ch.ready
//   is high only while the converter is idle. When the receiver holds ready
//   low the current character holds and the emitter stops; the converter
//   finishes its shift loop and holds its result until the emitter is free.
// ----------------------------------------------------------------------------
module integer_to_decimal_ascii #(
  parameter int MAX_DIGITS = 20
) (
  input  logic      clk,
  input  logic      rst,
  i2d_in_if.sink    in_ch,
  i2d_out_if.source out_ch
);

  localparam int PAD_W = $clog2(MAX_DIGITS + 1);
  localparam int LEN_W = (PAD_W > 5) ? PAD_W : 5;

  logic                 start;
  logic                 start_ready;
  logic                 xfer_valid;
  logic                 xfer_ready;
  i2d_pkg::bcd_xfer_t   xfer_data;
  logic [PAD_W-1:0]     pad_sat;
  logic [PAD_W-1:0]     pad_xfer;
  logic [LEN_W-1:0]     min_ext;

  assign in_ch.ready = start_ready;
  assign start       = in_ch.valid && start_ready;
  assign min_ext     = LEN_W'(in_ch.min_digits);

  // zero ignores padding; saturate the minimum at MAX_DIGITS
  always_comb begin
    if (in_ch.value == 64'd0) begin
      pad_sat = '0;
    end else if (min_ext > LEN_W'(MAX_DIGITS)) begin
      pad_sat = PAD_W'(MAX_DIGITS);
    end else begin
      pad_sat = min_ext[PAD_W-1:0];
    end
  end

  i2d_conv #(
    .PAD_W (PAD_W)
  ) u_conv (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .start_ready (start_ready),
    .value       (in_ch.value),
    .pad_in      (pad_sat),
    .done_valid  (xfer_valid),
    .done_ready  (xfer_ready),
    .done_data   (xfer_data),
    .pad_out     (pad_xfer)
  );

  i2d_emit #(
    .PAD_W (PAD_W),
    .LEN_W (LEN_W)
  ) u_emit (
    .clk        (clk),
    .rst        (rst),
    .load_valid (xfer_valid),
    .load_ready (xfer_ready),
    .load_data  (xfer_data),
    .pad_in     (pad_xfer),
    .out_ch     (out_ch)
  );

endmodule

[sim/integer_to_decimal_ascii_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii_checker
// Watches both channels of the converter. Every integer taken in is turned
// into its expected characters. Each character sent out is compared with the
// oldest expected one, and mismatches are counted for the testbench top.
// ----------------------------------------------------------------------------
module integer_to_decimal_ascii_checker #(
  parameter int MAX_DIGITS = 20
) (
  input  logic clk,
  input  logic rst,
  i2d_in_if    in_ch,
  i2d_out_if   out_ch,
  output int   mismatch_count,
  output int   chars_pending
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [6:0] digit_char;
    logic       is_last;
    logic       negative_error;
    logic [4:0] length;
  } char_rec_t;

  char_rec_t expected_chars[$];

  // queue the characters that one integer should produce
  function automatic void predict_chars(input logic [63:0] value,
                                        input logic [4:0] min_digits);
    logic [63:0] mag;
    logic [3:0]  digits[$];
    int          pad;
    int          total;
    int          pos;
    char_rec_t   rec;
    if (value[63]) begin
      rec = '{digit_char: 7'd0, is_last: 1'b1, negative_error: 1'b1, length: 5'd0};
      expected_chars.push_back(rec);
    end else if (value == 64'd0) begin
      // padding does not apply to zero
      rec = '{digit_char: i2d_pkg::CHAR_ZERO, is_last: 1'b1, negative_error: 1'b0,
              length: 5'd1};
      expected_chars.push_back(rec);
    end else begin
      pad = (int'(min_digits) > MAX_DIGITS) ? MAX_DIGITS : int'(min_digits);
      mag = value;
      while (mag != 64'd0) begin
        digits.push_back(4'(mag % 64'd10));
        mag = mag / 64'd10;
      end
      total = (digits.size() < pad) ? pad : digits.size();
      for (int k = 0; k < total; k++) begin
        pos = total - 1 - k;
        rec.digit_char     = i2d_pkg::CHAR_ZERO + ((pos < digits.size()) ? 7'(digits[pos]) : 7'd0);
        rec.is_last        = (k == total - 1);
        rec.negative_error = 1'b0;
        rec.length         = 5'(k + 1);
        expected_chars.push_back(rec);
      end
    end
  endfunction

  always @(posedge clk) begin
    char_rec_t got;
    char_rec_t want;
    if (rst) begin
      expected_chars.delete();
      mismatch_count = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_chars(in_ch.value, in_ch.min_digits);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{digit_char: out_ch.digit_char, is_last: out_ch.is_last,
                negative_error: out_ch.negative_error, length: out_ch.length};
        if (expected_chars.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: unexpected character %h last %b err %b len %0d", $realtime,
                     got.digit_char, got.is_last, got.negative_error, got.length);
          end
        end else begin
          want = expected_chars.pop_front();
          if (got.digit_char !== want.digit_char || got.is_last !== want.is_last ||
              got.negative_error !== want.negative_error || got.length !== want.length) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("%0t: mismatch expected char %h last %b err %b len %0d", $realtime,
                       want.digit_char, want.is_last, want.negative_error, want.length);
              $display("%0t:          got      char %h last %b err %b len %0d", $realtime,
                       got.digit_char, got.is_last, got.negative_error, got.length);
            end
          end
        end
      end
    end
    chars_pending = expected_chars.size();
  end

endmodule

[sim/integer_to_decimal_ascii_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii_tb
// Feeds the converter a directed set of corner values (extremes, zero,
// negatives, padding at and above its bound) and then random integers of
// varied magnitude, with random gaps on both channels. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module integer_to_decimal_ascii_tb;

  localparam int MAX_DIGITS   = 20;
  localparam int RANDOM_ITEMS = 250;
  localparam int GAP_PERCENT  = 13;
  localparam int DRAIN_CYCLES = 150;
  localparam int CYCLE_LIMIT  = 400000;

  logic clk = 1'b0;
  logic rst;
  logic no_gaps;
  int   cycle_count = 0;
  int   mismatch_count;
  int   chars_pending;

  i2d_in_if  in_ch ();
  i2d_out_if out_ch ();

  integer_to_decimal_ascii #(
    .MAX_DIGITS(MAX_DIGITS)
  ) uut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  integer_to_decimal_ascii_checker #(
    .MAX_DIGITS(MAX_DIGITS)
  ) char_check (
    .clk           (clk),
    .rst           (rst),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .mismatch_count(mismatch_count),
    .chars_pending (chars_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver stalls at random, except during the gap-free stretch
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= no_gaps || ($urandom_range(0, 99) >= GAP_PERCENT);
    end
  end

  task automatic send_int(input logic [63:0] value, input logic [4:0] min_digits);
    while (!no_gaps && $urandom_range(0, 99) < GAP_PERCENT) begin
      in_ch.valid      <= 1'b0;
      in_ch.value      <= {$urandom, $urandom};
      in_ch.min_digits <= 5'($urandom);
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.value      <= value;
    in_ch.min_digits <= min_digits;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // hold off the sender until every expected character has arrived
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [63:0] value;
    logic [63:0] raw;
    logic [4:0]  min_digits;
    int          sel;
    int          width;
    in_ch.valid      = 1'b0;
    in_ch.value      = 64'd0;
    in_ch.min_digits = 5'd0;
    no_gaps          = 1'b0;
    rst              = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero ignores padding
    send_int(64'd0, 5'd0);
    send_int(64'd0, 5'd31);
    // negatives give the error result only
    send_int(64'hFFFF_FFFF_FFFF_FFFF, 5'd5);
    send_int(64'h8000_0000_0000_0000, 5'd0);
    send_int(64'h8000_0000_0000_0001, 5'd31);
    // padding below, at and above the bound
    send_int(64'd1, 5'd0);
    send_int(64'd1, 5'd1);
    send_int(64'd1, 5'd20);
    send_int(64'd1, 5'd21);
    send_int(64'd1, 5'd31);
    send_int(64'd7, 5'd19);
    send_int(64'd12345, 5'd3);
    send_int(64'd12345, 5'd5);
    send_int(64'd12345, 5'd6);
    // digit count boundaries
    send_int(64'd9, 5'd0);
    send_int(64'd10, 5'd0);
    send_int(64'd99, 5'd2);
    send_int(64'd100, 5'd0);
    send_int(64'd999_999_999, 5'd0);
    send_int(64'd1_000_000_000, 5'd0);
    send_int(64'd999_999_999_999_999_999, 5'd0);
    send_int(64'd1_000_000_000_000_000_000, 5'd0);
    // largest positive value, 19 digits, padded to 20 and beyond
    send_int(64'h7FFF_FFFF_FFFF_FFFF, 5'd0);
    send_int(64'h7FFF_FFFF_FFFF_FFFF, 5'd20);
    send_int(64'h7FFF_FFFF_FFFF_FFFF, 5'd31);
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      no_gaps = (i >= 120 && i < 180);
      raw = {$urandom, $urandom};
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        value = {1'b1, raw[62:0]};
      end else if (sel < 15) begin
        value = 64'd0;
      end else begin
        width = $urandom_range(1, 63);
        value = raw & ((64'd1 << width) - 64'd1);
      end
      if ($urandom_range(0, 99) < 70) begin
        min_digits = 5'($urandom_range(0, MAX_DIGITS));
      end else begin
        min_digits = 5'($urandom_range(0, 31));
      end
      send_int(value, min_digits);
      if (i % 60 == 59) begin
        wait_drained();
      end
    end
    no_gaps = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && chars_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
